[sv/motor_fault_supervisor_assert.svh]
// Assertion macros for the motor fault supervisor.
// Included by the top level only; needs a clock and an active high reset.
`ifndef MOTOR_FAULT_SUPERVISOR_ASSERT_SVH
`define MOTOR_FAULT_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MFS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfs: check failed");

// Next-cycle implication, disabled during reset
`define MFS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfs: check failed");

`endif

[sv/mfs_pkg.sv]
// Types and constants shared by the motor fault supervisor.
// No dependencies.
`default_nettype none

package mfs_pkg;

  localparam int unsigned MaxMotors = 4;

  // Request codes
  typedef enum logic [1:0] {
    REQ_CHECK     = 2'd0,
    REQ_HEARTBEAT = 2'd1,
    REQ_CAN       = 2'd2,
    REQ_CLEAR     = 2'd3
  } req_type_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HB_TIMEOUT  = 2'd0,
    CFG_DRIVE_THR   = 2'd1,
    CFG_STUCK_LIMIT = 2'd2
  } cfg_index_t;

  // Fault bit positions
  localparam int unsigned FbTimeout = 0;
  localparam int unsigned FbStall   = 1;
  localparam int unsigned FbEncoder = 2;
  localparam int unsigned FbCan     = 3;

  // Register reset values
  localparam logic [15:0] HbTimeoutRst  = 16'd300;
  localparam logic [14:0] DriveThrRst   = 15'd1638;
  localparam logic [7:0]  StuckLimitRst = 8'd100;

  localparam logic [7:0] StuckCntMax = 8'd255;

  typedef struct packed {
    logic [15:0] heartbeat_timeout;
    logic [14:0] drive_threshold;
    logic [7:0]  stuck_limit;
  } cfg_t;

  typedef struct packed {
    req_type_t                     req_type;
    logic [31:0]                   tick_now;
    logic                          can_fault_level;
    logic [MaxMotors-1:0][15:0]    duty;
    logic [MaxMotors-1:0][31:0]    enc_delta;
    logic [MaxMotors-1:0]          overcurrent_mask;
  } item_t;

endpackage

`default_nettype wire

[sv/mfs_ifs.sv]
// Valid/ready channel interfaces for request and result items.
// No dependencies.
`default_nettype none

interface mfs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [31:0]        tick_now;
  logic               can_fault_level;
  logic signed [15:0] duty_m0;
  logic signed [15:0] duty_m1;
  logic signed [15:0] duty_m2;
  logic signed [15:0] duty_m3;
  logic signed [31:0] enc_delta_m0;
  logic signed [31:0] enc_delta_m1;
  logic signed [31:0] enc_delta_m2;
  logic signed [31:0] enc_delta_m3;
  logic [3:0]         overcurrent_mask;

  modport source (
    output valid, req_type, tick_now, can_fault_level,
           duty_m0, duty_m1, duty_m2, duty_m3,
           enc_delta_m0, enc_delta_m1, enc_delta_m2, enc_delta_m3,
           overcurrent_mask,
    input  ready
  );

  modport sink (
    input  valid, req_type, tick_now, can_fault_level,
           duty_m0, duty_m1, duty_m2, duty_m3,
           enc_delta_m0, enc_delta_m1, enc_delta_m2, enc_delta_m3,
           overcurrent_mask,
    output ready
  );
endinterface

interface mfs_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] fault_bits;
  logic [3:0] overcurrent_seen;

  modport source (output valid, fault_bits, overcurrent_seen, input ready);
  modport sink   (input valid, fault_bits, overcurrent_seen, output ready);
endinterface

`default_nettype wire

[sv/motor_fault_supervisor.sv]
// Motor fault supervisor, four motors, one result item per request item.
// Item path: input register, then evaluation into the result register and
// supervisor state. Throughput: one item per cycle while results are taken;
// the state loop is a single evaluation pass.
// Reset (rst, synchronous): clears faults, counters, latches, heartbeat tick
// and both pipeline stages; registers return to 300 / 1638 / 100.
`default_nettype none

`include "motor_fault_supervisor_assert.svh"

module motor_fault_supervisor import mfs_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  mfs_req_if.sink     req,
  mfs_rsp_if.source   rsp,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [3:0] MotorMask = 4'((1 << MOTOR_COUNT) - 1);

  cfg_t                        cfg;
  item_t                       in_item;
  item_t                       s1_item;
  logic                        s1_valid;
  logic                        out_valid;
  logic [3:0]                  out_fault;
  logic [3:0]                  out_oc;
  logic                        out_free;
  logic                        advance;
  logic                        in_fire;

  logic [31:0]                 hb_tick;
  logic [3:0]                  fault;
  logic [MOTOR_COUNT-1:0][7:0] stuck_count;
  logic [3:0]                  oc_latch;
  logic [31:0]                 hb_tick_next;
  logic [3:0]                  fault_next;
  logic [MOTOR_COUNT-1:0][7:0] stuck_count_next;
  logic [3:0]                  oc_latch_next;

  // Handshake: the result register frees up when taken
  assign out_free  = !out_valid || rsp.ready;
  assign advance   = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;
  assign in_fire   = req.valid && req.ready;

  assign rsp.valid            = out_valid;
  assign rsp.fault_bits       = out_fault;
  assign rsp.overcurrent_seen = out_oc;

  // Gather the incoming item
  always_comb begin
    in_item.req_type         = req_type_t'(req.req_type);
    in_item.tick_now         = req.tick_now;
    in_item.can_fault_level  = req.can_fault_level;
    in_item.duty             = {req.duty_m3, req.duty_m2, req.duty_m1, req.duty_m0};
    in_item.enc_delta        = {req.enc_delta_m3, req.enc_delta_m2,
                                req.enc_delta_m1, req.enc_delta_m0};
    in_item.overcurrent_mask = req.overcurrent_mask;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heartbeat_timeout <= HbTimeoutRst;
      cfg.drive_threshold   <= DriveThrRst;
      cfg.stuck_limit       <= StuckLimitRst;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_HB_TIMEOUT:  cfg.heartbeat_timeout <= cfg_wdata;
        CFG_DRIVE_THR:   cfg.drive_threshold   <= cfg_wdata[14:0];
        CFG_STUCK_LIMIT: cfg.stuck_limit       <= cfg_wdata[7:0];
        default: begin
          cfg.stuck_limit <= cfg.stuck_limit;
        end
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_item;
    end
  end

  mfs_eval #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_eval (
    .item             (s1_item),
    .cfg              (cfg),
    .hb_tick          (hb_tick),
    .fault            (fault),
    .stuck_count      (stuck_count),
    .oc_latch         (oc_latch),
    .hb_tick_next     (hb_tick_next),
    .fault_next       (fault_next),
    .stuck_count_next (stuck_count_next),
    .oc_latch_next    (oc_latch_next)
  );

  // Supervisor state, updated as each item leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      hb_tick     <= '0;
      fault       <= '0;
      stuck_count <= '0;
      oc_latch    <= '0;
    end else if (advance) begin
      hb_tick     <= hb_tick_next;
      fault       <= fault_next;
      stuck_count <= stuck_count_next;
      oc_latch    <= oc_latch_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_fault <= fault_next;
      out_oc    <= oc_latch_next;
    end
  end

  // Checks
  `MFS_ASSERT_IMP(a_oc_motors, clk, rst, out_valid, (out_oc & ~MotorMask) == 4'd0)
  `MFS_ASSERT_NXT(a_clear_result, clk, rst, advance && (s1_item.req_type == REQ_CLEAR), (out_fault == 4'd0) && (out_oc == 4'd0))
  `MFS_ASSERT_NXT(a_hb_clears_tmo, clk, rst, advance && (s1_item.req_type == REQ_HEARTBEAT), !out_fault[FbTimeout])
  `MFS_ASSERT_IMP(a_enc_has_count, clk, rst, fault[FbEncoder], stuck_count != '0)

endmodule

`default_nettype wire

[sv/mfs_eval.sv]
// Next-state evaluation for one request item of the fault supervisor.
// Depends on mfs_pkg. Purely combinational.
`default_nettype none

module mfs_eval import mfs_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  item_t                        item,
  input  cfg_t                         cfg,
  input  logic [31:0]                  hb_tick,
  input  logic [3:0]                   fault,
  input  logic [MOTOR_COUNT-1:0][7:0]  stuck_count,
  input  logic [3:0]                   oc_latch,
  output logic [31:0]                  hb_tick_next,
  output logic [3:0]                   fault_next,
  output logic [MOTOR_COUNT-1:0][7:0]  stuck_count_next,
  output logic [3:0]                   oc_latch_next
);

  localparam logic [3:0] MotorMask = 4'((1 << MOTOR_COUNT) - 1);

  logic [MOTOR_COUNT-1:0]      stall_m;
  logic [MOTOR_COUNT-1:0]      stuck_m;
  logic [MOTOR_COUNT-1:0][7:0] cnt_chk;
  logic [31:0]                 elapsed;
  logic                        timeout_hit;

  // Per-motor stall and stuck-encoder detection
  for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_motor
    logic signed [15:0] duty;
    logic               drive_still;
    assign duty        = item.duty[g];
    assign drive_still = (duty > $signed({1'b0, cfg.drive_threshold}))
                         && (item.enc_delta[g] == '0);
    assign stall_m[g]  = item.overcurrent_mask[g] && (duty > 16'sd0);
    // counter saturates at its maximum
    assign cnt_chk[g]  = !drive_still ? 8'd0 :
                         (stuck_count[g] == StuckCntMax) ? stuck_count[g] :
                         stuck_count[g] + 8'd1;
    assign stuck_m[g]  = drive_still && (cnt_chk[g] >= cfg.stuck_limit);
  end

  // Modular tick difference against the timeout
  assign elapsed     = item.tick_now - hb_tick;
  assign timeout_hit = elapsed > {16'd0, cfg.heartbeat_timeout};

  // Request dispatch
  always_comb begin
    hb_tick_next     = hb_tick;
    fault_next       = fault;
    stuck_count_next = stuck_count;
    oc_latch_next    = oc_latch;
    case (item.req_type)
      REQ_CHECK: begin
        // heartbeat tick still zero: timeout bit untouched
        if (hb_tick != '0) begin
          fault_next[FbTimeout] = timeout_hit;
        end
        fault_next[FbStall]   = |stall_m;
        fault_next[FbEncoder] = |stuck_m;
        stuck_count_next      = cnt_chk;
        oc_latch_next         = item.overcurrent_mask & MotorMask;
      end
      REQ_HEARTBEAT: begin
        hb_tick_next          = item.tick_now;
        fault_next[FbTimeout] = 1'b0;
      end
      REQ_CAN: begin
        fault_next[FbCan] = item.can_fault_level;
      end
      REQ_CLEAR: begin
        fault_next       = '0;
        stuck_count_next = '0;
        oc_latch_next    = '0;
      end
      default: begin
        fault_next = fault;
      end
    endcase
  end

endmodule

`default_nettype wire

[tb/sv/tb_motor_fault_supervisor.sv]
`timescale 1ns / 100ps
// Self-checking bench for motor_fault_supervisor: directed and random request items,
// with each result item checked against a behavioural model of the fault logic.
// Depends on mfs_pkg, the mfs_req_if / mfs_rsp_if interfaces and the supervisor RTL.

module tb_motor_fault_supervisor;
  import mfs_pkg::*;

  localparam int unsigned MotorCount = 4;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    logic [3:0] fault_bits;
    logic [3:0] overcurrent_seen;
  } status_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  cfg_index_t  cfg_index;
  logic [15:0] cfg_wdata;

  mfs_req_if req ();
  mfs_rsp_if rsp ();

  motor_fault_supervisor #(.MOTOR_COUNT(MotorCount)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Model of the supervisor state and its registers
  cfg_t        cfg;
  logic [31:0] beat_tick;
  logic [3:0]  faults;
  logic [7:0]  still_cnt [MaxMotors];
  logic [3:0]  oc_latch;

  status_t     status_q [$];
  int unsigned err_cnt = 0;
  int unsigned rsp_hold = 0;
  bit          no_idle;
  logic [31:0] sim_tick;
  logic [31:0] last_beat;
  int unsigned sticky_motor;

  always #10 clk = ~clk;

  function automatic void reset_model();
    cfg.heartbeat_timeout = HbTimeoutRst;
    cfg.drive_threshold   = DriveThrRst;
    cfg.stuck_limit       = StuckLimitRst;
    beat_tick = '0;
    faults    = '0;
    oc_latch  = '0;
    foreach (still_cnt[m]) still_cnt[m] = '0;
  endfunction

  function automatic void set_reg(cfg_index_t idx, logic [15:0] val);
    case (idx)
      CFG_HB_TIMEOUT:  cfg.heartbeat_timeout = val;
      CFG_DRIVE_THR:   cfg.drive_threshold   = val[14:0];
      CFG_STUCK_LIMIT: cfg.stuck_limit       = val[7:0];
      default: ;
    endcase
  endfunction

  // Applies one request to the model and returns the status it answers with
  function automatic status_t supervise(item_t it);
    logic [31:0] elapsed;
    logic [3:0]  oc;
    logic        stall;
    logic        stuck;
    logic        driven;
    case (it.req_type)
      REQ_CHECK: begin
        // timeout only once a nonzero heartbeat tick is held; modular difference
        if (beat_tick != '0) begin
          elapsed = it.tick_now - beat_tick;
          faults[FbTimeout] = elapsed > 32'(cfg.heartbeat_timeout);
        end
        oc    = '0;
        stall = 1'b0;
        stuck = 1'b0;
        for (int m = 0; m < MotorCount; m++) begin
          oc[m] = it.overcurrent_mask[m];
          if (oc[m] && $signed(it.duty[m]) > 16'sd0) stall = 1'b1;
          driven = $signed(it.duty[m]) > $signed({1'b0, cfg.drive_threshold});
          if (driven && it.enc_delta[m] == '0) begin
            if (still_cnt[m] != StuckCntMax) still_cnt[m]++;
            if (still_cnt[m] >= cfg.stuck_limit) stuck = 1'b1;
          end else begin
            still_cnt[m] = '0;
          end
        end
        oc_latch          = oc;
        faults[FbStall]   = stall;
        faults[FbEncoder] = stuck;
      end
      REQ_HEARTBEAT: begin
        beat_tick         = it.tick_now;
        faults[FbTimeout] = 1'b0;
      end
      REQ_CAN: begin
        faults[FbCan] = it.can_fault_level;
      end
      default: begin
        // clear-all keeps the heartbeat tick
        faults   = '0;
        oc_latch = '0;
        foreach (still_cnt[m]) still_cnt[m] = '0;
      end
    endcase
    return {faults, oc_latch};
  endfunction

  // Sends one item after a random lead-in gap (none when no_idle is set) and queues its expected status
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.req_type         <= it.req_type;
    req.tick_now         <= it.tick_now;
    req.can_fault_level  <= it.can_fault_level;
    req.duty_m0          <= it.duty[0];
    req.duty_m1          <= it.duty[1];
    req.duty_m2          <= it.duty[2];
    req.duty_m3          <= it.duty[3];
    req.enc_delta_m0     <= it.enc_delta[0];
    req.enc_delta_m1     <= it.enc_delta[1];
    req.enc_delta_m2     <= it.enc_delta[2];
    req.enc_delta_m3     <= it.enc_delta[3];
    req.overcurrent_mask <= it.overcurrent_mask;
    req.valid            <= 1'b1;
    do @(posedge clk); while (!req.ready);
    status_q.push_back(supervise(it));
  endtask

  task automatic drain_results();
    @(negedge clk);
    req.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    set_reg(idx, val);
  endtask

  // Registers change only once the block has gone idle
  task automatic set_config(logic [15:0] tmo, logic [14:0] thr, logic [7:0] lim);
    drain_results();
    write_reg(CFG_HB_TIMEOUT, tmo);
    write_reg(CFG_DRIVE_THR, {1'b0, thr});
    write_reg(CFG_STUCK_LIMIT, {8'd0, lim});
  endtask

  function automatic item_t blank(req_type_t kind, logic [31:0] tick);
    item_t it;
    it          = '0;
    it.req_type = kind;
    it.tick_now = tick;
    return it;
  endfunction

  // Duty strictly above the drive threshold, or full scale if none exists
  function automatic logic [15:0] driving_duty();
    if (cfg.drive_threshold == 15'h7fff) return 16'h7fff;
    return 16'(cfg.drive_threshold + $urandom_range(1, 32767 - cfg.drive_threshold));
  endfunction

  // Mostly well-formed traffic around the heartbeat window, the rest noise
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    int unsigned r;
    logic [31:0] span;
    it.req_type        = req_type_t'($urandom_range(0, 3));
    it.tick_now        = $urandom;
    it.can_fault_level = 1'($urandom_range(0, 1));
    for (int m = 0; m < MaxMotors; m++) begin
      it.duty[m]      = 16'($urandom);
      it.enc_delta[m] = $urandom;
    end
    it.overcurrent_mask = 4'($urandom_range(0, 15));
    span = 32'(cfg.heartbeat_timeout);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      return it;
    end else if (pick < 72) begin
      it.req_type = REQ_CHECK;
      case ($urandom_range(0, 3))
        0:       it.tick_now = last_beat + span + 32'($urandom_range(0, 2)) - 32'd1;
        3:       it.tick_now = last_beat + span + 32'($urandom_range(1, 2000));
        default: it.tick_now = last_beat + 32'($urandom_range(0, span));
      endcase
      for (int m = 0; m < MaxMotors; m++) begin
        r = $urandom_range(0, 9);
        if ((m == sticky_motor && r != 0) || r < 4) begin
          it.duty[m]      = driving_duty();
          it.enc_delta[m] = '0;
        end else if (r < 6) begin
          it.duty[m] = driving_duty();
        end else if (r < 8) begin
          it.enc_delta[m] = '0;
        end
        it.overcurrent_mask[m] = ($urandom_range(0, 4) == 0);
      end
    end else if (pick < 84) begin
      it.req_type = REQ_HEARTBEAT;
      sim_tick    = sim_tick + 32'($urandom_range(1, 50));
      r = $urandom_range(0, 19);
      if (r == 0) it.tick_now = '0;
      else if (r < 3) it.tick_now = 32'hffff_ff00 + 32'($urandom_range(0, 255));
      else it.tick_now = sim_tick;
      last_beat = it.tick_now;
    end else if (pick < 93) begin
      it.req_type = REQ_CAN;
    end else begin
      it.req_type = REQ_CLEAR;
    end
    return it;
  endfunction

  // Result checker: field by field against the oldest expectation
  always @(posedge clk) begin
    status_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (status_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= ReportMax)
          $display("%0t: result with nothing expected: faults %b oc %b", $time,
                   rsp.fault_bits, rsp.overcurrent_seen);
      end else begin
        want = status_q.pop_front();
        if (rsp.fault_bits !== want.fault_bits ||
            rsp.overcurrent_seen !== want.overcurrent_seen) begin
          err_cnt++;
          if (err_cnt <= ReportMax)
            $display("%0t: mismatch: faults exp %b got %b, oc exp %b got %b", $time,
                     want.fault_bits, rsp.fault_bits,
                     want.overcurrent_seen, rsp.overcurrent_seen);
        end
      end
      rsp_hold <= no_idle ? 0 : $urandom_range(0, 15);
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (rsp_hold > 0) begin
      rsp.ready <= 1'b0;
      rsp_hold  <= rsp_hold - 1;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Defaults after reset: request kinds, timeout edges, tick wrap, duty extremes
  task automatic test_default_regs();
    item_t it;
    // no heartbeat held yet: timeout skipped; overcurrent at full duty stalls
    it = blank(REQ_CHECK, 32'd5000);
    for (int m = 0; m < MaxMotors; m++) it.duty[m] = 16'h7fff;
    it.overcurrent_mask = 4'hf;
    send_item(it);
    send_item(blank(REQ_HEARTBEAT, 32'd1000));
    send_item(blank(REQ_CHECK, 32'd1300));
    send_item(blank(REQ_CHECK, 32'd1301));
    it = blank(REQ_CAN, 32'd0);
    it.can_fault_level = 1'b1;
    send_item(it);
    send_item(blank(REQ_HEARTBEAT, 32'd1400));
    send_item(blank(REQ_CLEAR, 32'd0));
    // heartbeat tick survives clear-all
    send_item(blank(REQ_CHECK, 32'd1701));
    send_item(blank(REQ_CAN, 32'd0));
    // heartbeat at tick zero returns to the no-heartbeat condition
    send_item(blank(REQ_HEARTBEAT, 32'd0));
    send_item(blank(REQ_CHECK, 32'hffff_ffff));
    // elapsed time across the tick wrap
    send_item(blank(REQ_HEARTBEAT, 32'hffff_ff00));
    send_item(blank(REQ_CHECK, 32'h0000_002b));
    send_item(blank(REQ_CHECK, 32'h0000_002d));
    // duty and encoder extremes
    it = blank(REQ_CHECK, 32'h0000_002c);
    it.duty[0]      = 16'h8000;
    it.duty[1]      = 16'h0000;
    it.duty[2]      = 16'h0001;
    it.duty[3]      = 16'h7fff;
    it.enc_delta[0] = 32'h0000_0000;
    it.enc_delta[1] = 32'h8000_0000;
    it.enc_delta[2] = 32'hffff_ffff;
    it.enc_delta[3] = 32'h7fff_ffff;
    it.overcurrent_mask = 4'hf;
    send_item(it);
    // duty at and just above the drive threshold
    it = blank(REQ_CHECK, 32'h0000_0030);
    it.duty[0] = 16'(DriveThrRst);
    it.duty[1] = 16'(DriveThrRst) + 16'd1;
    it.overcurrent_mask = 4'h5;
    send_item(it);
    it = blank(REQ_CAN, 32'd0);
    it.can_fault_level = 1'b1;
    send_item(it);
    send_item(blank(REQ_CHECK, 32'h0000_0031));
    send_item(blank(REQ_CLEAR, 32'd0));
  endtask

  // Counter saturation at the top limit, then a limit of zero
  task automatic test_stuck_counters();
    item_t it;
    set_config(HbTimeoutRst, 15'd0, 8'd255);
    for (int n = 0; n < 262; n++) begin
      it = blank(REQ_CHECK, $urandom);
      for (int m = 0; m < MaxMotors; m++) begin
        it.duty[m]      = 16'($urandom);
        it.enc_delta[m] = $urandom_range(0, 1) ? 32'd0 : $urandom;
      end
      it.duty[1]      = 16'($urandom_range(1, 32767));
      it.enc_delta[1] = (n == 259) ? 32'd1 : 32'd0;
      it.overcurrent_mask = 4'($urandom_range(0, 15));
      send_item(it);
    end
    set_config(HbTimeoutRst, 15'd0, 8'd0);
    it = blank(REQ_CHECK, 32'd0);
    it.duty[3] = 16'd1;
    send_item(it);
    send_item(blank(REQ_CLEAR, 32'd0));
  endtask

  // Random traffic over several register settings, extremes included
  task automatic test_random_traffic();
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_config(HbTimeoutRst, DriveThrRst, 8'd6);
        1: set_config(16'd0, 15'd0, 8'd1);
        2: set_config(16'hffff, 15'h7fff, 8'd255);
        3: set_config(16'd1, 15'h7ffe, 8'd0);
        default: set_config(16'($urandom_range(0, 2000)), 15'($urandom_range(0, 32767)),
                            8'($urandom_range(1, 20)));
      endcase
      no_idle      = (p % 3 == 1);
      sticky_motor = $urandom_range(0, MotorCount - 1);
      repeat (80) send_item(random_item());
    end
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_wr_en            = 1'b0;
    cfg_index            = CFG_HB_TIMEOUT;
    cfg_wdata            = '0;
    req.valid            = 1'b0;
    req.req_type         = '0;
    req.tick_now         = '0;
    req.can_fault_level  = 1'b0;
    req.duty_m0          = '0;
    req.duty_m1          = '0;
    req.duty_m2          = '0;
    req.duty_m3          = '0;
    req.enc_delta_m0     = '0;
    req.enc_delta_m1     = '0;
    req.enc_delta_m2     = '0;
    req.enc_delta_m3     = '0;
    req.overcurrent_mask = '0;
    rsp.ready            = 1'b0;
    no_idle              = 1'b0;
    sim_tick             = 32'd100;
    last_beat            = '0;
    sticky_motor         = 0;
    reset_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_regs();
    test_stuck_counters();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_motor_fault_supervisor: clean");
    end else begin
      $display("tb_motor_fault_supervisor: errors");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("tb_motor_fault_supervisor: errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/mfs_pkg.sv
sv/mfs_ifs.sv
sv/mfs_eval.sv
sv/motor_fault_supervisor.sv
tb/sv/tb_motor_fault_supervisor.sv
